>>> rtl/core/cdad_pkg.sv
`default_nettype none

package cdad_pkg;

    // Field widths of one input and one result word.
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned OFFSET_W = 16;

    // Packed widths of the payload buses, padded to whole bytes.
    localparam int unsigned DATE_W    = DAY_W + MONTH_W + YEAR_W;
    localparam int unsigned IN_BITS   = DATE_W + OFFSET_W;
    localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((DATE_W + 7) / 8) * 8;
    localparam int unsigned OUT_USER_W = 2;

    // Bit positions inside the result tuser.
    localparam int unsigned USER_VALID_BIT = 0;
    localparam int unsigned USER_ERR_BIT   = 1;

    // Calendar constants.
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT  = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_CYCLE  = 14'd400;
    localparam logic [8:0]         CYCLE_LAST  = 9'd399;
    localparam logic [8:0]         CENTURY_1   = 9'd100;
    localparam logic [8:0]         CENTURY_2   = 9'd200;
    localparam logic [8:0]         CENTURY_3   = 9'd300;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR   = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN   = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP   = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV   = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   DAYS_LONG   = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_SHORT  = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_FEB    = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_FEB_LP = 5'd29;

    // Leap year from the year reduced modulo 400.
    function automatic logic is_leap(input logic [8:0] ymod);
        logic century;
        century = (ymod == CENTURY_1) || (ymod == CENTURY_2) || (ymod == CENTURY_3);
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_FEB)
        begin
            len = leap ? DAYS_FEB_LP : DAYS_FEB;
        end
        else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                 (month == MONTH_SEP) || (month == MONTH_NOV))
        begin
            len = DAYS_SHORT;
        end
        else
        begin
            len = DAYS_LONG;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/calendar_date_add_days_unit.sv
`default_nettype none

// Gregorian date adder. Each input word carries a date and a signed day offset; each
// result word carries the moved date plus two flags. An invalid date (month outside
// 1..12, day 0 or past the end of its month) comes back unchanged with date_valid low.
// A result whose year would leave 0..9999 comes back as the input date with range_error
// set. The offset magnitude is clamped to MAX_OFFSET, so -32768 acts as -32767 by default.
// One word is worked on at a time and s_tready is low while it is in flight. A valid date
// passes through ST_REDUCE, a repeated subtract-400 that reduces the year for the leap
// rule, then ST_CHECK, then ST_FWD or ST_BWD, which walk the month boundaries and end
// with the final partial-month step, then ST_FINISH, the hand-off; an invalid date goes
// from ST_CHECK straight to ST_FINISH. One month boundary is crossed per cycle by the
// single add-compare-subtract unit on the remaining day count. s_tready returns in the
// same cycle as the result word appears. The finished result sits in an output register,
// and the block accepts the next word while it waits there; if that register is still
// full when the next result is done, the hand-off waits for it to drain.
module calendar_date_add_days_unit
    import cdad_pkg::*;
#(
    parameter int unsigned MAX_OFFSET = 32767
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata from bit 0: in_day[4:0], in_month[3:0], in_year[13:0],
    // offset_days[15:0] (signed), one zero pad bit.
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata from bit 0: out_day[4:0], out_month[3:0], out_year[13:0], one zero pad bit.
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // m_tuser from bit 0: date_valid, range_error.
    output logic [OUT_USER_W-1:0]      m_tuser
);

    localparam logic [31:0] MaxOff = 32'(MAX_OFFSET);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_FWD    = 3'd3;
    localparam logic [2:0] ST_BWD    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [DATE_W-1:0]   din_reg, din_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    // Holds the year during reduction, then the year modulo 400 in its low bits.
    logic [YEAR_W-1:0]   ymod_reg, ymod_next;
    logic [OFFSET_W-1:0] rem_reg, rem_next;
    logic                res_valid_reg, res_valid_next;
    logic                res_err_reg, res_err_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic [8:0]          ymod9;
    logic                leap;
    logic [DAY_W-1:0]    cur_len;
    logic [OFFSET_W:0]   fwd_sum;
    logic [OFFSET_W-1:0] off_mag;
    logic [DATE_W-1:0]   work_date;

    assign ymod9   = ymod_reg[8:0];
    assign leap    = is_leap(ymod9);
    assign cur_len = month_len(month_reg, leap);
    assign fwd_sum = {1'b0, rem_reg} + (OFFSET_W + 1)'(day_reg);
    // Two's-complement magnitude; the most negative offset maps to its true magnitude.
    assign off_mag = off_reg[OFFSET_W-1] ? (~off_reg + 1'b1) : off_reg;
    assign work_date = {year_reg, month_reg, day_reg};

    always_comb
    begin
        state_next     = state_reg;
        din_next       = din_reg;
        off_next       = off_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        ymod_next      = ymod_reg;
        rem_next       = rem_reg;
        res_valid_next = res_valid_reg;
        res_err_next   = res_err_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    din_next   = s_tdata[DATE_W-1:0];
                    off_next   = s_tdata[IN_BITS-1:DATE_W];
                    day_next   = s_tdata[DAY_W-1:0];
                    month_next = s_tdata[DAY_W+MONTH_W-1:DAY_W];
                    year_next  = s_tdata[DATE_W-1:DAY_W+MONTH_W];
                    ymod_next  = s_tdata[DATE_W-1:DAY_W+MONTH_W];
                    state_next = ST_REDUCE;
                end
            end

            ST_REDUCE:
            begin
                if (ymod_reg >= YEAR_CYCLE)
                begin
                    ymod_next = ymod_reg - YEAR_CYCLE;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                res_err_next = 1'b0;
                if ((month_reg < MONTH_JAN) || (month_reg > MONTH_DEC) ||
                    (day_reg == '0) || (day_reg > cur_len))
                begin
                    res_valid_next = 1'b0;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    if ({16'd0, off_mag} > MaxOff)
                    begin
                        rem_next = MaxOff[OFFSET_W-1:0];
                    end
                    else
                    begin
                        rem_next = off_mag;
                    end
                    state_next = off_reg[OFFSET_W-1] ? ST_BWD : ST_FWD;
                end
            end

            ST_FWD:
            begin
                if (fwd_sum > (OFFSET_W + 1)'(cur_len))
                begin
                    // Step to the first day of the next month.
                    rem_next = OFFSET_W'(fwd_sum - (OFFSET_W + 1)'(cur_len) - 1'b1);
                    day_next = DAY_W'(1);
                    if (month_reg == MONTH_DEC)
                    begin
                        if (year_reg >= YEAR_LIMIT)
                        begin
                            res_err_next = 1'b1;
                            state_next   = ST_FINISH;
                        end
                        month_next = MONTH_JAN;
                        year_next  = year_reg + 1'b1;
                        ymod_next  = (ymod9 == CYCLE_LAST) ? '0 : ymod_reg + 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
                else
                begin
                    day_next     = fwd_sum[DAY_W-1:0];
                    res_err_next = (year_reg > YEAR_LIMIT);
                    state_next   = ST_FINISH;
                end
            end

            ST_BWD:
            begin
                if (rem_reg >= OFFSET_W'(day_reg))
                begin
                    // Step to the last day of the previous month. The year only changes
                    // when that month is December, whose length ignores the leap rule.
                    rem_next = rem_reg - OFFSET_W'(day_reg);
                    if (month_reg == MONTH_JAN)
                    begin
                        if (year_reg == '0)
                        begin
                            res_err_next = 1'b1;
                            state_next   = ST_FINISH;
                        end
                        month_next = MONTH_DEC;
                        year_next  = year_reg - 1'b1;
                        ymod_next  = (ymod9 == '0) ? YEAR_W'(CYCLE_LAST) : ymod_reg - 1'b1;
                        day_next   = DAYS_LONG;
                    end
                    else
                    begin
                        month_next = month_reg - 1'b1;
                        day_next   = month_len(month_reg - 1'b1, leap);
                    end
                end
                else
                begin
                    day_next     = day_reg - rem_reg[DAY_W-1:0];
                    res_err_next = (year_reg > YEAR_LIMIT);
                    state_next   = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (!res_valid_reg || res_err_reg)
                    begin
                        out_data_next = OUT_DATA_W'(din_reg);
                    end
                    else
                    begin
                        out_data_next = OUT_DATA_W'(work_date);
                    end
                    out_user_next[USER_VALID_BIT] = res_valid_reg;
                    out_user_next[USER_ERR_BIT]   = res_err_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        din_reg       <= din_next;
        off_reg       <= off_next;
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
        ymod_reg      <= ymod_next;
        rem_reg       <= rem_next;
        res_valid_reg <= res_valid_next;
        res_err_reg   <= res_err_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

>>> rtl/core/cdad_checker.sv
`default_nettype none

module cdad_checker
    import cdad_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [OUT_USER_W-1:0] m_tuser
);

    logic [DAY_W-1:0]   o_day;
    logic [MONTH_W-1:0] o_month;
    logic [YEAR_W-1:0]  o_year;
    logic               in_seen;

    assign o_day   = m_tdata[DAY_W-1:0];
    assign o_month = m_tdata[DAY_W+MONTH_W-1:DAY_W];
    assign o_year  = m_tdata[DATE_W-1:DAY_W+MONTH_W];
    assign in_seen = s_tvalid && s_tready && (s_tdata[IN_DATA_W-1] == 1'b0);

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A range error is only reported for a date that passed the check.
    a_err_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[USER_ERR_BIT] && !m_tuser[USER_VALID_BIT]))
        else $error("range error on an invalid date");

    // A successful result is a plausible date inside the year range.
    a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_VALID_BIT] && !m_tuser[USER_ERR_BIT] |->
        (o_month >= MONTH_JAN) && (o_month <= MONTH_DEC) && (o_day != '0) &&
        (o_year <= YEAR_LIMIT))
        else $error("result date out of range");

    // After taking a word the block is busy on it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_seen |=> !s_tready)
        else $error("input ready right after an accepted word");

endmodule

bind calendar_date_add_days_unit cdad_checker u_cdad_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the Gregorian date adder. Every accepted input word is run
// through a behavioral calendar model in this file, unless its directed row holds a
// hand-written result, and the resulting date and flags are queued. Each result word
// leaving the block is compared field by field with the oldest queued date. A short
// directed table comes first. It covers invalid dates, leap-year corners, range errors
// at both ends of the year span and the saturated offset. Random words follow in four
// phases with different amounts of source idling and sink back pressure.
module tb_top;

    import cdad_pkg::*;

    localparam int MAX_OFFSET = 32767;

    // The watchdog gives up when no handshake has happened for far longer than the slowest word needs.
    localparam int WATCHDOG_LIMIT = 20000;

    // After the queue drains, this is how long we keep watching for stray output at the end of the run.
    localparam int DRAIN_CYCLES = 1300;

    localparam int RANDOM_PER_PHASE = 125;
    localparam int NUM_PHASES       = 4;

    // Input word, packed so that day lands in bit 0 of s_tdata.
    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset;
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
    } date_req_t;

    // Result word: the date from m_tdata with the two m_tuser flags on top.
    typedef struct packed {
        logic                 range_error;
        logic                 date_valid;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
    } date_res_t;

    // One row of the directed table. When fixed is set, want holds the hand-written
    // result. Otherwise the row is checked against the calendar model.
    typedef struct packed {
        date_req_t req;
        logic      fixed;
        date_res_t want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 24;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // Zero offset on a plain date returns the date itself.
        '{'{16'sd0, 14'd2024, 4'd1, 5'd1}, 1'b1, '{1'b0, 1'b1, 14'd2024, 4'd1, 5'd1}},
        // Day 0 is treated as an invalid date.
        '{'{16'sd5, 14'd2024, 4'd1, 5'd0}, 1'b1, '{1'b0, 1'b0, 14'd2024, 4'd1, 5'd0}},
        // A day past the end of a 30-day month is invalid.
        '{'{16'sd1, 14'd2023, 4'd4, 5'd31}, 1'b1, '{1'b0, 1'b0, 14'd2023, 4'd4, 5'd31}},
        // February 29 does not exist in a common year.
        '{'{16'sd1, 14'd2023, 4'd2, 5'd29}, 1'b1, '{1'b0, 1'b0, 14'd2023, 4'd2, 5'd29}},
        // February 29 of a leap year is valid.
        '{'{16'sd0, 14'd2024, 4'd2, 5'd29}, 1'b1, '{1'b0, 1'b1, 14'd2024, 4'd2, 5'd29}},
        // A century year that is not a multiple of 400 is not a leap year.
        '{'{16'sd1, 14'd1900, 4'd2, 5'd29}, 1'b1, '{1'b0, 1'b0, 14'd1900, 4'd2, 5'd29}},
        // A multiple of 400 is a leap year.
        '{'{16'sd1, 14'd2000, 4'd2, 5'd29}, 1'b0, '0},
        // Month 0 and the months above December are invalid.
        '{'{16'sd7, 14'd2024, 4'd0, 5'd1}, 1'b1, '{1'b0, 1'b0, 14'd2024, 4'd0, 5'd1}},
        '{'{16'sd7, 14'd2024, 4'd13, 5'd1}, 1'b1, '{1'b0, 1'b0, 14'd2024, 4'd13, 5'd1}},
        // Year, month and day at their top field values with either extreme offset. The date is invalid.
        '{'{16'sh7FFF, 14'd16383, 4'd15, 5'd31}, 1'b1,
          '{1'b0, 1'b0, 14'd16383, 4'd15, 5'd31}},
        '{'{16'sh8000, 14'd16383, 4'd15, 5'd31}, 1'b1,
          '{1'b0, 1'b0, 14'd16383, 4'd15, 5'd31}},
        // One step past the last day of year 9999 leaves the range.
        '{'{16'sd1, 14'd9999, 4'd12, 5'd31}, 1'b1, '{1'b1, 1'b1, 14'd9999, 4'd12, 5'd31}},
        // One step before the first day of year 0 leaves the range.
        '{'{-16'sd1, 14'd0, 4'd1, 5'd1}, 1'b1, '{1'b1, 1'b1, 14'd0, 4'd1, 5'd1}},
        // An input year above 9999 with no movement stays out of range.
        '{'{16'sd0, 14'd16383, 4'd1, 5'd1}, 1'b1, '{1'b1, 1'b1, 14'd16383, 4'd1, 5'd1}},
        // Largest forward offset from the very first date.
        '{'{16'sh7FFF, 14'd0, 4'd1, 5'd1}, 1'b0, '0},
        // The most negative offset is saturated to -MAX_OFFSET.
        '{'{16'sh8000, 14'd9999, 4'd12, 5'd31}, 1'b0, '0},
        '{'{16'sh7FFF, 14'd2024, 4'd6, 5'd15}, 1'b0, '0},
        '{'{-16'sd32767, 14'd2024, 4'd6, 5'd15}, 1'b0, '0},
        // Moving back from a year above 9999: one day back from 10000 gives a valid result.
        '{'{-16'sd1, 14'd10000, 4'd1, 5'd1}, 1'b0, '0},
        '{'{16'sh8000, 14'd16383, 4'd1, 5'd1}, 1'b0, '0},
        // Month and year rollover corners.
        '{'{16'sd1, 14'd2100, 4'd2, 5'd28}, 1'b0, '0},
        '{'{16'sd30, 14'd2023, 4'd1, 5'd31}, 1'b0, '0},
        '{'{-16'sd1, 14'd2024, 4'd3, 5'd1}, 1'b0, '0},
        '{'{16'sd1, 14'd2023, 4'd12, 5'd31}, 1'b0, '0}
    };

    // Source idle and sink stall rates per phase, in percent.
    localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 68, 0, 28};
    localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 68, 28};

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    date_res_t expected_dates [$];
    int        fail_count  = 0;
    int        quiet_count = 0;
    int        idle_pct    = 0;
    int        stall_pct   = 0;

    always #1 clk = ~clk;

    calendar_date_add_days_unit #(
        .MAX_OFFSET(MAX_OFFSET)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic bit is_leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in(input int m, input int y);
        if (m == MONTH_FEB)
        begin
            return is_leap_year(y) ? 29 : 28;
        end
        if ((m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) || (m == MONTH_NOV))
        begin
            return 30;
        end
        return 31;
    endfunction

    // Calendar model. It walks one month at a time, which is also how the block works.
    // A valid result is therefore the same date whatever route is taken to reach it.
    function automatic date_res_t add_days(input date_req_t req);
        date_res_t res;
        int        d;
        int        m;
        int        y;
        int        rem;
        int        len;
        int        prev;
        int        off;
        bit        err;
        res.day         = req.day;
        res.month       = req.month;
        res.year        = req.year;
        res.range_error = 1'b0;
        res.date_valid  = (req.month >= MONTH_JAN) && (req.month <= MONTH_DEC) &&
                          (req.day >= 1) && (int'(req.day) <= days_in(req.month, req.year));
        if (!res.date_valid)
        begin
            return res;
        end
        off = int'(req.offset);
        if (off > MAX_OFFSET)
        begin
            off = MAX_OFFSET;
        end
        if (off < -MAX_OFFSET)
        begin
            off = -MAX_OFFSET;
        end
        d   = req.day;
        m   = req.month;
        y   = req.year;
        err = 1'b0;
        if (off >= 0)
        begin
            rem = off;
            len = days_in(m, y);
            while (d + rem > len)
            begin
                rem -= (len - d) + 1;
                d = 1;
                if (m == MONTH_DEC)
                begin
                    m = MONTH_JAN;
                    y++;
                end
                else
                begin
                    m++;
                end
                if (y > int'(YEAR_LIMIT))
                begin
                    err = 1'b1;
                    break;
                end
                len = days_in(m, y);
            end
            if (!err)
            begin
                d += rem;
            end
        end
        else
        begin
            rem = -off;
            while (d - rem < 1)
            begin
                prev = (m == MONTH_JAN) ? MONTH_DEC : m - 1;
                rem -= d;
                if (m == MONTH_JAN)
                begin
                    y--;
                    m = MONTH_DEC;
                end
                else
                begin
                    m--;
                end
                if (y < 0)
                begin
                    err = 1'b1;
                    break;
                end
                d = days_in(prev, y);
            end
            if (!err)
            begin
                d -= rem;
            end
        end
        if (err || (y > int'(YEAR_LIMIT)) || (y < 0))
        begin
            res.range_error = 1'b1;
        end
        else
        begin
            res.day   = d[DAY_W-1:0];
            res.month = m[MONTH_W-1:0];
            res.year  = y[YEAR_W-1:0];
        end
        return res;
    endfunction

    // Most random words are valid dates, so that the block actually walks months. A quarter
    // of their years lie near both ends of the range or above it, to provoke range errors.
    // The rest are raw noise or dates with a broken day.
    function automatic date_req_t random_request();
        date_req_t req;
        int        sel;
        int        y;
        int        m;
        int        o;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            req.day    = DAY_W'($urandom);
            req.month  = MONTH_W'($urandom);
            req.year   = YEAR_W'($urandom);
            req.offset = OFFSET_W'($urandom);
            return req;
        end
        case ($urandom_range(19))
            0, 1:    y = $urandom_range(60);
            2, 3:    y = $urandom_range(9999, 9940);
            4:       y = $urandom_range(16383, 10000);
            default: y = $urandom_range(9999);
        endcase
        m         = $urandom_range(12, 1);
        req.year  = y[YEAR_W-1:0];
        req.month = m[MONTH_W-1:0];
        req.day   = DAY_W'($urandom_range(days_in(m, y), 1));
        // A few dates get day 0 or a day just past the end of the month.
        if (sel < 20)
        begin
            req.day = (sel < 17) ? 5'd0 : DAY_W'($urandom_range(31, days_in(m, y) + 1));
        end
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            o = int'($urandom_range(800)) - 400;
        end
        else if (sel < 70)
        begin
            o = int'($urandom_range(10000)) - 5000;
        end
        else if (sel < 90)
        begin
            o = int'($signed(16'($urandom)));
        end
        else
        begin
            case ($urandom_range(4))
                0:       o = -32768;
                1:       o = 32767;
                2:       o = -1;
                3:       o = 1;
                default: o = 0;
            endcase
        end
        req.offset = OFFSET_W'(o);
        return req;
    endfunction

    // Present one word, idling at random first. The expectation is queued at the edge
    // where the word is taken. valid stays high afterwards, and the next call or the
    // caller decides whether to lower it.
    task automatic send_word(input date_req_t req, input bit fixed, input date_res_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(req);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_dates.push_back(fixed ? want : add_days(req));
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Sink side: m_tready follows the stall rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker and watchdog. Values sampled here are the ones from before the edge.
    always @(posedge clk)
    begin
        date_res_t got;
        date_res_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_count = 0;
            end
            else
            begin
                quiet_count++;
            end
            if (quiet_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
            else if (m_tvalid && m_tready)
            begin
                got = {m_tuser[USER_ERR_BIT], m_tuser[USER_VALID_BIT], m_tdata[DATE_W-1:0]};
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: result word with nothing outstanding, got %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    report_field("out_day", want.day, got.day);
                    report_field("out_month", want.month, got.month);
                    report_field("out_year", want.year, got.year);
                    report_field("date_valid", want.date_valid, got.date_valid);
                    report_field("range_error", want.range_error, got.range_error);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_pct  = PHASE_IDLE[ph];
            stall_pct = PHASE_STALL[ph];
            // The directed table runs in the first phase, with no idling on either side.
            if (ph == 0)
            begin
                foreach (DIRECTED[i])
                begin
                    send_word(DIRECTED[i].req, DIRECTED[i].fixed, DIRECTED[i].want);
                end
            end
            repeat (RANDOM_PER_PHASE)
            begin
                send_word(random_request(), 1'b0, '0);
            end
            // Hold the source off until every queued result has come back.
            s_tvalid <= 1'b0;
            while (expected_dates.size() != 0)
            begin
                @(posedge clk);
            end
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> calendar_date_add_days_unit.f
rtl/core/cdad_pkg.sv
rtl/core/calendar_date_add_days_unit.sv
rtl/core/cdad_checker.sv
test/tb_top.sv
